// ===== rtl/sqdj_pkg.sv =====
// ----------------------------------------------------------------------------
// sqdj_pkg
// Shared types and constants for the shortest-queue dispatcher with jockeying.
// ----------------------------------------------------------------------------
package sqdj_pkg;

  localparam int TICK_W = 32;
  localparam int SUM_W  = 48;
  localparam int CNT_W  = 32;
  localparam int SID_W  = 3;
  localparam int ACT_W  = 2;
  localparam int MOVE_W = 3;

  localparam int DEF_SERVERS     = 2;
  localparam int DEF_QUEUE_DEPTH = 16;

  // Event kinds.
  localparam logic REQ_ARRIVAL    = 1'b0;
  localparam logic REQ_COMPLETION = 1'b1;

  // Result action codes.
  localparam logic [ACT_W-1:0] ACT_START  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUEUE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RESUME = 2'd2;
  localparam logic [ACT_W-1:0] ACT_IDLE   = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic [TICK_W-1:0] event_tick;
    logic [SID_W-1:0]  server_id;
  } in_data_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SID_W-1:0]  target_server;
    logic              dropped;
    logic [TICK_W-1:0] wait_ticks;
    logic [MOVE_W-1:0] jockey_moves;
    logic [SUM_W-1:0]  total_wait;
    logic [CNT_W-1:0]  departure_total;
  } out_data_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ARR_SCAN,
    ST_ARR_PUSH,
    ST_DEP_LOAD,
    ST_JOCK_CMP,
    ST_JOCK_WR,
    ST_DEP_POP,
    ST_DEP_WAIT,
    ST_DEP_ACC,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/sqdj_ram.sv =====
// ----------------------------------------------------------------------------
// sqdj_ram
// Queue entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sqdj_ram
  import sqdj_pkg::*;
#(
  parameter int DEPTH  = DEF_SERVERS * DEF_QUEUE_DEPTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [TICK_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [TICK_W-1:0] rdata
);

  logic [TICK_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/shortest_queue_dispatch_jockey.sv =====
// ----------------------------------------------------------------------------
// shortest_queue_dispatch_jockey
// Dispatcher for SERVERS servers with one FIFO of waiting customers each.
// ----------------------------------------------------------------------------
// Each beat is an arrival or a service completion and yields exactly one
// result beat. The block handles one event at a time with a small sequencer
// around one count comparator and one single-port-read queue RAM. An arrival
// runs the idle/shortest-queue scan over the servers until one is idle, an
// enqueue step when no server is idle and a step that loads the output
// register. A completion loads the server's queue state, walks the other
// servers for jockeying (each move adds a RAM read-then-write step), pops
// its queue and, when a queued customer starts, computes and accumulates
// the wait before the output register is loaded. A completion at a server
// number of SERVERS or above goes straight to loading the output register.
// The input side is stalled while an event is in progress; a finished result
// waits in the output register without blocking the next input beat, and the
// next result is held back only for as long as that earlier beat is stalled.
// Queue entries are not cleared at reset; only entries that were written are
// ever read.
// ----------------------------------------------------------------------------
module shortest_queue_dispatch_jockey
  import sqdj_pkg::*;
#(
  parameter int SERVERS     = DEF_SERVERS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_data_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_data_t out_data
);

  localparam int SW    = $clog2(SERVERS);
  localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS = SERVERS * QUEUE_DEPTH;
  localparam int AW    = $clog2(SLOTS);

  state_t state_r, state_nxt;

  logic [TICK_W-1:0] tick_r;
  logic [SID_W-1:0]  sid_r;
  logic [SW-1:0]     idx_r;
  logic [SW-1:0]     step_r;
  logic [SW-1:0]     best_r;
  logic [CW-1:0]     best_cnt_r;
  logic [CW-1:0]     cnt_s_r;
  logic [HW-1:0]     head_s_r;
  logic [MOVE_W-1:0] moves_r;
  logic [TICK_W-1:0] wait_r;
  logic [ACT_W-1:0]  res_action_r;
  logic [SID_W-1:0]  res_target_r;
  logic              res_dropped_r;

  logic [SERVERS-1:0] idle_r;
  logic [HW-1:0]      heads_r  [SERVERS];
  logic [CW-1:0]      counts_r [SERVERS];
  logic [SUM_W-1:0]   wait_sum_r;
  logic [CNT_W-1:0]   dep_cnt_r;

  logic      out_valid_r;
  out_data_t out_data_r;

  logic              accept;
  logic              out_free;
  logic              bad_sid;
  logic              last_step;
  logic [SW-1:0]     sid_s;
  logic [SW-1:0]     pos_dec;
  logic [CW-1:0]     cur_cnt;
  logic [HW-1:0]     cur_head;
  logic              cur_idle;
  logic              scan_better;
  logic [SW-1:0]     scan_best;
  logic [CW-1:0]     scan_best_cnt;
  logic [TICK_W:0]   diff;
  logic [SUM_W:0]    sum_ext;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [TICK_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [TICK_W-1:0] mem_rdata;

  // Position of entry at head + k in a circular queue of QUEUE_DEPTH slots.
  function automatic logic [HW-1:0] wrap_off(input logic [HW-1:0] h,
                                             input logic [CW-1:0] c);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(c);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return s[HW-1:0];
  endfunction

  function automatic logic [HW-1:0] head_inc(input logic [HW-1:0] h);
    return (h == HW'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot(input logic [SW-1:0] q,
                                         input logic [HW-1:0] off);
    return AW'(q) * AW'(QUEUE_DEPTH) + AW'(off);
  endfunction

  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign bad_sid    = {1'b0, in_data.server_id} >= (SID_W+1)'(SERVERS);
  assign sid_s      = sid_r[SW-1:0];
  assign last_step  = (step_r == SW'(SERVERS - 1));
  assign pos_dec    = (idx_r == '0) ? SW'(SERVERS - 1) : idx_r - 1'b1;
  assign cur_cnt    = counts_r[idx_r];
  assign cur_head   = heads_r[idx_r];
  assign cur_idle   = idle_r[idx_r];

  // Shortest-queue tracking; ties keep the lower index.
  assign scan_better   = (idx_r == '0) || (cur_cnt < best_cnt_r);
  assign scan_best     = scan_better ? idx_r : best_r;
  assign scan_best_cnt = scan_better ? cur_cnt : best_cnt_r;

  assign diff    = {1'b0, tick_r} - {1'b0, mem_rdata};
  assign sum_ext = {1'b0, wait_sum_r} + (SUM_W+1)'(wait_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_ARRIVAL) begin
            state_nxt = ST_ARR_SCAN;
          end else if (bad_sid) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_DEP_LOAD;
          end
        end
      end
      ST_ARR_SCAN: begin
        if (cur_idle) begin
          state_nxt = ST_EMIT;
        end else if (idx_r == SW'(SERVERS - 1)) begin
          state_nxt = ST_ARR_PUSH;
        end
      end
      ST_ARR_PUSH: state_nxt = ST_EMIT;
      ST_DEP_LOAD: state_nxt = ST_JOCK_CMP;
      ST_JOCK_CMP: begin
        if (cnt_s_r < cur_cnt) begin
          state_nxt = ST_JOCK_WR;
        end else if (last_step) begin
          state_nxt = ST_DEP_POP;
        end
      end
      ST_JOCK_WR:  state_nxt = last_step ? ST_DEP_POP : ST_JOCK_CMP;
      ST_DEP_POP:  state_nxt = (cnt_s_r == '0) ? ST_EMIT : ST_DEP_WAIT;
      ST_DEP_WAIT: state_nxt = ST_DEP_ACC;
      ST_DEP_ACC:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake and RAM port controls.
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = mem_rdata;
    mem_waddr = slot(sid_s, wrap_off(head_s_r, cnt_s_r));
    mem_raddr = slot(idx_r, cur_head);
    case (state_r)
      ST_ARR_PUSH: begin
        mem_we    = (best_cnt_r < CW'(QUEUE_DEPTH));
        mem_wdata = tick_r;
        mem_waddr = slot(idx_r, wrap_off(cur_head, best_cnt_r));
      end
      ST_JOCK_CMP: begin
        mem_re = (cnt_s_r < cur_cnt);
      end
      ST_JOCK_WR: begin
        mem_we = 1'b1;
      end
      ST_DEP_POP: begin
        mem_re    = (cnt_s_r != '0);
        mem_raddr = slot(sid_s, head_s_r);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Queue bookkeeping and totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r     <= '1;
      wait_sum_r <= '0;
      dep_cnt_r  <= '0;
      for (int i = 0; i < SERVERS; i++) begin
        heads_r[i]  <= '0;
        counts_r[i] <= '0;
      end
    end else begin
      case (state_r)
        ST_ARR_SCAN: begin
          if (cur_idle) begin
            idle_r[idx_r] <= 1'b0;
          end
        end
        ST_ARR_PUSH: begin
          if (best_cnt_r < CW'(QUEUE_DEPTH)) begin
            counts_r[idx_r] <= best_cnt_r + 1'b1;
          end
        end
        ST_JOCK_CMP: begin
          if (cnt_s_r < cur_cnt) begin
            counts_r[idx_r] <= cur_cnt - 1'b1;
            heads_r[idx_r]  <= head_inc(cur_head);
          end
        end
        ST_JOCK_WR: begin
          counts_r[sid_s] <= cnt_s_r + 1'b1;
        end
        ST_DEP_POP: begin
          if (cnt_s_r == '0) begin
            idle_r[sid_s] <= 1'b1;
            if (dep_cnt_r != '1) begin
              dep_cnt_r <= dep_cnt_r + 1'b1;
            end
          end else begin
            idle_r[sid_s]   <= 1'b0;
            heads_r[sid_s]  <= head_inc(head_s_r);
            counts_r[sid_s] <= cnt_s_r - 1'b1;
          end
        end
        ST_DEP_ACC: begin
          wait_sum_r <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
          if (dep_cnt_r != '1) begin
            dep_cnt_r <= dep_cnt_r + 1'b1;
          end
        end
        default: begin
          idle_r <= idle_r;
        end
      endcase
    end
  end

  // Per-event working registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          tick_r        <= in_data.event_tick;
          sid_r         <= in_data.server_id;
          idx_r         <= (in_data.req_type == REQ_ARRIVAL) ? '0
                                                             : in_data.server_id[SW-1:0];
          step_r        <= SW'(1);
          moves_r       <= '0;
          wait_r        <= '0;
          res_dropped_r <= 1'b0;
          res_action_r  <= ACT_IDLE;
          res_target_r  <= in_data.server_id;
        end
      end
      ST_ARR_SCAN: begin
        best_r     <= scan_best;
        best_cnt_r <= scan_best_cnt;
        if (cur_idle) begin
          res_action_r <= ACT_START;
          res_target_r <= SID_W'(idx_r);
        end else if (idx_r == SW'(SERVERS - 1)) begin
          idx_r <= scan_best;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      ST_ARR_PUSH: begin
        res_action_r  <= ACT_QUEUE;
        res_target_r  <= SID_W'(idx_r);
        res_dropped_r <= !(best_cnt_r < CW'(QUEUE_DEPTH));
      end
      ST_DEP_LOAD: begin
        cnt_s_r  <= cur_cnt;
        head_s_r <= cur_head;
        idx_r    <= pos_dec;
      end
      ST_JOCK_CMP: begin
        if (!(cnt_s_r < cur_cnt)) begin
          step_r <= step_r + 1'b1;
          idx_r  <= pos_dec;
        end
      end
      ST_JOCK_WR: begin
        cnt_s_r <= cnt_s_r + 1'b1;
        moves_r <= moves_r + 1'b1;
        step_r  <= step_r + 1'b1;
        idx_r   <= pos_dec;
      end
      ST_DEP_POP: begin
        res_target_r <= sid_r;
        res_action_r <= (cnt_s_r == '0) ? ACT_IDLE : ACT_RESUME;
      end
      ST_DEP_WAIT: begin
        // A tick older than the enqueue time counts as no wait.
        wait_r <= diff[TICK_W] ? '0 : diff[TICK_W-1:0];
      end
      default: begin
        tick_r <= tick_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      out_data_r.action          <= res_action_r;
      out_data_r.target_server   <= res_target_r;
      out_data_r.dropped         <= res_dropped_r;
      out_data_r.wait_ticks      <= wait_r;
      out_data_r.jockey_moves    <= moves_r;
      out_data_r.total_wait      <= wait_sum_r;
      out_data_r.departure_total <= dep_cnt_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  sqdj_ram #(
    .DEPTH  (SLOTS),
    .ADDR_W (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The jockey walk never visits the departing server itself.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_JOCK_CMP) |-> (idx_r != sid_s))
    else $error("jockey walk visited the departing server");

  // A new result beat only appears out of the emit step.
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> ($past(state_r) == ST_EMIT))
    else $error("result beat raised outside the emit step");

  // Totals are monotonic between resets.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((wait_sum_r >= $past(wait_sum_r)) &&
                      (dep_cnt_r >= $past(dep_cnt_r))))
    else $error("running totals decreased");

  // The enqueue step sees a count that a queue can really hold.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ARR_PUSH) |-> (best_cnt_r <= CW'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");

endmodule

// ===== bench/tb_shortest_queue_dispatch_jockey.sv =====
// ----------------------------------------------------------------------------
// tb_shortest_queue_dispatch_jockey
// Self-checking bench for the shortest-queue dispatcher with jockeying.
// ----------------------------------------------------------------------------
// A short table of hand-picked events comes first. A few of its rows carry a
// hand-written result; the rest are checked against a behavioral model of
// the dispatcher kept in this bench. Random phases follow. Some phases are
// heavy on arrivals and fill the queues up to drops, and others drain them.
// Both sides of the block idle in short random bursts. Once, the result side
// holds off for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_shortest_queue_dispatch_jockey;
  import sqdj_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSRV          = DEF_SERVERS;
  localparam int QDEPTH        = DEF_QUEUE_DEPTH;
  localparam int RANDOM_ITEMS  = 1425;
  localparam int TAIL_ITEMS    = 150;
  localparam int HOLD_AT_ITEM  = 600;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 24;
  localparam int CYCLE_LIMIT   = 250000;

  typedef struct {
    in_data_t  ev;
    bit        fixed;
    out_data_t want;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_data_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_data_t out_data;

  logic hold_req = 1'b0;
  logic quiet_tail = 1'b0;

  out_data_t   expected_q[$];
  int          fail_count = 0;
  int unsigned result_count = 0;
  int unsigned cycle_count = 0;

  // Mirror of the dispatcher state.
  bit                srv_idle[NSRV];
  logic [TICK_W-1:0] fifo_mem[NSRV][QDEPTH];
  int unsigned       fifo_head[NSRV];
  int unsigned       fifo_fill[NSRV];
  logic [SUM_W-1:0]  wait_total;
  logic [CNT_W-1:0]  done_count;

  shortest_queue_dispatch_jockey #(
    .SERVERS    (NSRV),
    .QUEUE_DEPTH(QDEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void fifo_put(int q, logic [TICK_W-1:0] v);
    fifo_mem[q][(fifo_head[q] + fifo_fill[q]) % QDEPTH] = v;
    fifo_fill[q]++;
  endfunction

  function automatic logic [TICK_W-1:0] fifo_take(int q);
    logic [TICK_W-1:0] v;
    v = fifo_mem[q][fifo_head[q]];
    fifo_head[q] = (fifo_head[q] + 1) % QDEPTH;
    fifo_fill[q]--;
    return v;
  endfunction

  // Applies one event to the mirror state and returns the result beat it causes.
  function automatic out_data_t dispatch_predict(in_data_t ev);
    out_data_t         r;
    int                pick;
    int                sid;
    int                pos;
    bit                found;
    logic [TICK_W-1:0] t0;
    logic [SUM_W:0]    sum_wide;
    r = '0;
    if (ev.req_type == REQ_ARRIVAL) begin
      found = 1'b0;
      pick = 0;
      for (int i = NSRV - 1; i >= 0; i--) begin
        if (srv_idle[i]) begin
          found = 1'b1;
          pick = i;
        end
      end
      if (found) begin
        srv_idle[pick] = 1'b0;
        r.action = ACT_START;
        r.target_server = SID_W'(pick);
      end else begin
        pick = 0;
        for (int i = 1; i < NSRV; i++) begin
          if (fifo_fill[i] < fifo_fill[pick]) pick = i;
        end
        r.action = ACT_QUEUE;
        r.target_server = SID_W'(pick);
        if (fifo_fill[pick] < QDEPTH) fifo_put(pick, ev.event_tick);
        else r.dropped = 1'b1;
      end
    end else if (ev.server_id >= NSRV) begin
      r.action = ACT_IDLE;
      r.target_server = ev.server_id;
    end else begin
      sid = ev.server_id;
      // Walk the other servers downward, wrapping, and pull heads of longer queues.
      for (int i = 1; i < NSRV; i++) begin
        pos = (sid + NSRV - i) % NSRV;
        if (fifo_fill[sid] < fifo_fill[pos]) begin
          fifo_put(sid, fifo_take(pos));
          r.jockey_moves = r.jockey_moves + 1'b1;
        end
      end
      r.target_server = ev.server_id;
      if (fifo_fill[sid] == 0) begin
        srv_idle[sid] = 1'b1;
        r.action = ACT_IDLE;
      end else begin
        t0 = fifo_take(sid);
        srv_idle[sid] = 1'b0;
        r.action = ACT_RESUME;
        r.wait_ticks = (ev.event_tick >= t0) ? ev.event_tick - t0 : '0;
        sum_wide = wait_total + r.wait_ticks;
        wait_total = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      end
      if (done_count != '1) done_count = done_count + 1'b1;
    end
    r.total_wait = wait_total;
    r.departure_total = done_count;
    return r;
  endfunction

  function automatic plan_row_t mk_row(logic kind, logic [TICK_W-1:0] tick,
                                       logic [SID_W-1:0] sid, bit fixed,
                                       logic [ACT_W-1:0] act, logic [SID_W-1:0] tgt,
                                       logic [SUM_W-1:0] tot, logic [CNT_W-1:0] deps);
    plan_row_t row;
    row.ev.req_type = kind;
    row.ev.event_tick = tick;
    row.ev.server_id = sid;
    row.fixed = fixed;
    row.want = '0;
    row.want.action = act;
    row.want.target_server = tgt;
    row.want.total_wait = tot;
    row.want.departure_total = deps;
    return row;
  endfunction

  function automatic int burst_len(int pct);
    if ($urandom_range(0, 99) < pct) return $urandom_range(1, 7);
    return 0;
  endfunction

  function automatic void report_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("result %0d: %s expected %0h, got %0h", result_count, field, want, got);
      end
    end
  endfunction

  // Offers one beat, holds it until accepted, then records what must come back.
  task automatic push_beat(input in_data_t ev, input bit fixed, input out_data_t want,
                           input int gap);
    out_data_t predicted;
    in_data  <= ev;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = dispatch_predict(ev);
    if (fixed) predicted = want;
    expected_q = {expected_q, predicted};
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_data_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("result %0d: none expected, got %h", result_count, out_data);
        end
      end else begin
        want = expected_q.pop_front();
        report_field("action", want.action, out_data.action);
        report_field("target_server", want.target_server, out_data.target_server);
        report_field("dropped", want.dropped, out_data.dropped);
        report_field("wait_ticks", want.wait_ticks, out_data.wait_ticks);
        report_field("jockey_moves", want.jockey_moves, out_data.jockey_moves);
        report_field("total_wait", want.total_wait, out_data.total_wait);
        report_field("departure_total", want.departure_total, out_data.departure_total);
      end
      result_count++;
    end
  end

  // Result side pacing: changing stall density, one long hold-off on request.
  always begin : rx_pacing
    int rx_left;
    int rx_pct;
    @(posedge clk);
    if (rx_left == 0) begin
      rx_left = $urandom_range(100, 300);
      case ($urandom_range(0, 2))
        0: rx_pct = 0;
        1: rx_pct = 10;
        default: rx_pct = 35;
      endcase
    end
    rx_left--;
    if (quiet_tail) begin
      out_stall <= 1'b0;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_stall <= 1'b0;
      hold_req  <= 1'b0;
    end else if ($urandom_range(0, 99) < rx_pct) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t         plan[$];
    in_data_t          ev;
    logic [TICK_W-1:0] tick_now;
    int                sent;
    int                phase_len;
    int                arr_pct;
    int                tx_pct;
    bit                hold_armed;
    bit                first_phase;

    for (int i = 0; i < NSRV; i++) begin
      srv_idle[i] = 1'b1;
      fifo_head[i] = 0;
      fifo_fill[i] = 0;
    end
    wait_total = '0;
    done_count = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Completion at a missing server, completion at an idle server, both servers
    // started, first queued arrivals, jockeying, a backward tick that clamps the
    // wait, and ticks at both ends of their range.
    plan = {plan, mk_row(REQ_COMPLETION, 0, 7, 1, ACT_IDLE, 7, 0, 0)};
    plan = {plan, mk_row(REQ_COMPLETION, 0, 0, 1, ACT_IDLE, 0, 0, 1)};
    plan = {plan, mk_row(REQ_ARRIVAL, 0, 0, 1, ACT_START, 0, 0, 1)};
    plan = {plan, mk_row(REQ_ARRIVAL, 1, 7, 1, ACT_START, 1, 0, 1)};
    plan = {plan, mk_row(REQ_ARRIVAL, 2, 0, 1, ACT_QUEUE, 0, 0, 1)};
    plan = {plan, mk_row(REQ_ARRIVAL, 3, 0, 1, ACT_QUEUE, 1, 0, 1)};
    plan = {plan, mk_row(REQ_ARRIVAL, 4, 0, 0, ACT_START, 0, 0, 0)};
    plan = {plan, mk_row(REQ_COMPLETION, 100, 0, 0, ACT_START, 0, 0, 0)};
    plan = {plan, mk_row(REQ_COMPLETION, 50, 1, 0, ACT_START, 0, 0, 0)};
    plan = {plan, mk_row(REQ_ARRIVAL, 60, 0, 0, ACT_START, 0, 0, 0)};
    plan = {plan, mk_row(REQ_ARRIVAL, 61, 0, 0, ACT_START, 0, 0, 0)};
    plan = {plan, mk_row(REQ_ARRIVAL, 62, 0, 0, ACT_START, 0, 0, 0)};
    plan = {plan, mk_row(REQ_ARRIVAL, 63, 0, 0, ACT_START, 0, 0, 0)};
    plan = {plan, mk_row(REQ_ARRIVAL, 64, 0, 0, ACT_START, 0, 0, 0)};
    plan = {plan, mk_row(REQ_ARRIVAL, 65, 0, 0, ACT_START, 0, 0, 0)};
    plan = {plan, mk_row(REQ_COMPLETION, 70, 1, 0, ACT_START, 0, 0, 0)};
    plan = {plan, mk_row(REQ_COMPLETION, 30, 0, 0, ACT_START, 0, 0, 0)};
    plan = {plan, mk_row(REQ_ARRIVAL, 32'hFFFF_FFFF, 0, 0, ACT_START, 0, 0, 0)};
    plan = {plan, mk_row(REQ_COMPLETION, 32'hFFFF_FFFF, 1, 0, ACT_START, 0, 0, 0)};
    plan = {plan, mk_row(REQ_COMPLETION, 32'hFFFF_FFFF, 0, 0, ACT_START, 0, 0, 0)};
    plan = {plan, mk_row(REQ_COMPLETION, 32'hFFFF_FFFF, 0, 0, ACT_START, 0, 0, 0)};
    plan = {plan, mk_row(REQ_COMPLETION, 32'hFFFF_FFFF, 1, 0, ACT_START, 0, 0, 0)};
    plan = {plan, mk_row(REQ_COMPLETION, 0, 4, 0, ACT_START, 0, 0, 0)};
    plan = {plan, mk_row(REQ_COMPLETION, 5, 0, 0, ACT_START, 0, 0, 0)};

    foreach (plan[i]) push_beat(plan[i].ev, plan[i].fixed, plan[i].want, burst_len(30));

    tick_now = 32'd10;
    sent = 0;
    hold_armed = 1'b0;
    first_phase = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      // The first phase floods the queues so that drops show up early.
      if (first_phase) begin
        phase_len = 70;
        arr_pct = 90;
        tx_pct = 20;
        first_phase = 1'b0;
      end else begin
        phase_len = $urandom_range(10, 80);
        case ($urandom_range(0, 3))
          0: arr_pct = 20;
          1: arr_pct = 45;
          2: arr_pct = 60;
          default: arr_pct = 85;
        endcase
        case ($urandom_range(0, 2))
          0: tx_pct = 0;
          1: tx_pct = 15;
          default: tx_pct = 40;
        endcase
      end
      repeat (phase_len) begin
        if (sent < RANDOM_ITEMS) begin
          if ($urandom_range(0, 59) == 0) tick_now = $urandom();
          else tick_now = tick_now + $urandom_range(0, 40);
          ev.event_tick = tick_now;
          if ($urandom_range(0, 99) < arr_pct) begin
            ev.req_type = REQ_ARRIVAL;
            ev.server_id = SID_W'($urandom_range(0, 7));
          end else begin
            ev.req_type = REQ_COMPLETION;
            if ($urandom_range(0, 9) == 0) ev.server_id = SID_W'($urandom_range(0, 7));
            else ev.server_id = SID_W'($urandom_range(0, NSRV - 1));
          end
          if (sent >= RANDOM_ITEMS - TAIL_ITEMS && !quiet_tail) quiet_tail <= 1'b1;
          if (sent >= HOLD_AT_ITEM && !hold_armed) begin
            hold_req <= 1'b1;
            hold_armed = 1'b1;
          end
          push_beat(ev, 1'b0, '0, quiet_tail ? 0 : burst_len(tx_pct));
          sent++;
        end
      end
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
